// ===== sv/nrte_pkg.sv =====
// Shared types, constants and helpers for the RMC time extractor.
// No dependencies; imported by every module of the block.
`default_nettype none
package nrte_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned NibbleW    = 4;
  localparam int unsigned NumDigits  = 6;
  localparam int unsigned FieldW     = 7;
  localparam int unsigned OutDataW   = 24;
  localparam int unsigned QueueDepth = 2;

  localparam logic [ByteW-1:0] ChDollar = 8'h24;
  localparam logic [ByteW-1:0] ChZero   = 8'h30;
  localparam logic [ByteW-1:0] ChNine   = 8'h39;

  localparam logic [3:0] PosIdle      = 4'd0;
  localparam logic [3:0] PosHeaderEnd = 4'd6;
  localparam logic [3:0] PosTimeFirst = 4'd7;
  localparam logic [3:0] PosTimeLast  = 4'd12;

  typedef logic [NumDigits-1:0][NibbleW-1:0] time_digits_t;

  function automatic logic [ByteW-1:0] header_char(input logic [3:0] pos);
    logic [ByteW-1:0] ch;
    unique case (pos)
      4'd1:    ch = 8'h47;
      4'd2:    ch = 8'h50;
      4'd3:    ch = 8'h52;
      4'd4:    ch = 8'h4d;
      4'd5:    ch = 8'h43;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [FieldW-1:0] pair_value(input logic [NibbleW-1:0] hi,
                                                   input logic [NibbleW-1:0] lo);
    logic [7:0] sum;
    sum = {1'b0, hi, 3'b000} + {3'b000, hi, 1'b0} + {4'b0000, lo};
    return sum[FieldW-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== sv/nrte_front.sv =====
// Front end: tracks sentence position, checks the GPRMC header and captures time digits.
// Depends on nrte_pkg; pushes finished digit sets into nrte_queue.
`default_nettype none
module nrte_front
  import nrte_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire logic [ByteW-1:0]   rx_byte_i,
  output      logic               push_o,
  output      time_digits_t       push_data_o
);

  logic [3:0]   pos_q, pos_d;
  logic         hdr_bad_q, hdr_bad_d;
  logic         dig_bad_q, dig_bad_d;
  time_digits_t digits_q;
  logic         not_digit;
  logic [ByteW-1:0] nib_full;
  logic [2:0]   slot;

  assign not_digit = (rx_byte_i < ChZero) || (rx_byte_i > ChNine);
  assign nib_full  = rx_byte_i - ChZero;
  assign slot      = 3'(pos_q - PosTimeFirst);

  always_comb begin
    pos_d     = pos_q;
    hdr_bad_d = hdr_bad_q;
    dig_bad_d = dig_bad_q;
    push_o    = 1'b0;
    if (accept_i) begin
      if (pos_q == PosIdle) begin
        if (rx_byte_i == ChDollar) begin
          pos_d     = 4'd1;
          hdr_bad_d = 1'b0;
          dig_bad_d = 1'b0;
        end
      end else if (pos_q < PosHeaderEnd) begin
        if (rx_byte_i != header_char(pos_q)) hdr_bad_d = 1'b1;
        pos_d = pos_q + 4'd1;
      end else if (pos_q == PosHeaderEnd) begin
        pos_d = hdr_bad_q ? PosIdle : PosTimeFirst;
      end else if (pos_q < PosTimeLast) begin
        if (not_digit) dig_bad_d = 1'b1;
        pos_d = pos_q + 4'd1;
      end else if (pos_q == PosTimeLast) begin
        if (not_digit) dig_bad_d = 1'b1;
        push_o = !(dig_bad_q || not_digit);
        pos_d  = PosIdle;
      end else begin
        pos_d = PosIdle;
      end
    end
  end

  always_comb begin
    push_data_o                = digits_q;
    push_data_o[NumDigits-1]   = nib_full[NibbleW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= PosIdle;
      hdr_bad_q <= 1'b0;
      dig_bad_q <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      hdr_bad_q <= hdr_bad_d;
      dig_bad_q <= dig_bad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && pos_q >= PosTimeFirst && pos_q < PosTimeLast) begin
      digits_q[slot] <= nib_full[NibbleW-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== sv/nrte_queue.sv =====
// Short register queue carrying captured digit sets from front end to back end.
// Depends on nrte_pkg for the digit set type.
`default_nettype none
module nrte_queue
  import nrte_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire time_digits_t push_data_i,
  output      logic         not_full_o,
  output      logic         not_empty_o,
  input  wire logic         pop_i,
  output      time_digits_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  time_digits_t    mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign not_full_o  = count_q != CntW'(Depth);
  assign not_empty_o = count_q != '0;
  assign do_push     = push_i && not_full_o;
  assign do_pop      = pop_i && not_empty_o;
  assign pop_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      if (do_push && !do_pop)      count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule
`default_nettype wire

// ===== sv/nrte_back.sv =====
// Back end: converts digit pairs to binary and holds the result in the output register.
// Depends on nrte_pkg; pops digit sets from nrte_queue.
`default_nettype none
module nrte_back
  import nrte_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              avail_i,
  input  wire time_digits_t      digits_i,
  output      logic              pop_o,
  output      logic              m_tvalid_o,
  input  wire logic              m_tready_i,
  output      logic [OutDataW-1:0] m_tdata_o
);

  logic              valid_q;
  logic [FieldW-1:0] hours_q, minutes_q, seconds_q;

  assign pop_o      = avail_i && (!valid_q || m_tready_i);
  assign m_tvalid_o = valid_q;
  assign m_tdata_o  = {(OutDataW - 3 * FieldW)'(0), seconds_q, minutes_q, hours_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (m_tready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      hours_q   <= pair_value(digits_i[0], digits_i[1]);
      minutes_q <= pair_value(digits_i[2], digits_i[3]);
      seconds_q <= pair_value(digits_i[4], digits_i[5]);
    end
  end

endmodule
`default_nettype wire

// ===== sv/nmea_rmc_time_extractor.sv =====
// Top level of the RMC time extractor: front end, digit queue and back end.
// Depends on nrte_pkg, nrte_front, nrte_queue and nrte_back.
//
// Usage:
//   Feed received ASCII bytes on the s_axis channel, one request per byte.
//   A '$' opens a sentence; positions 1 to 5 must read GPRMC, position 6 is
//   skipped, positions 7 to 12 are the hhmmss characters. When all six are
//   decimal digits, one request leaves on m_axis with hours, minutes and
//   seconds in binary.
//   Throughput: one byte per cycle while s_axis_tready_o is high; the front
//   end decides each byte combinationally from the position counter and one compare.
//   After the byte at position 12 is taken, the digit set is written into the queue,
//   then converted into the output register once that register is free or drained.
//   Reset clears the position counter, the queue and the output valid; the
//   block is ready for a byte right after reset, as the queue starts empty.
//   When the receiver stalls, results wait in the digit queue (two entries by
//   default) and the output register; s_axis_tready_o drops only when the queue is full.
`default_nettype none
module nmea_rmc_time_extractor
  import nrte_pkg::*;
#(
  parameter int unsigned QueueDepthP = QueueDepth
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output      logic                s_axis_tready_o,
  input  wire logic [ByteW-1:0]    s_axis_tdata_i,   // [7:0] rx_byte
  output      logic                m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  output      logic [OutDataW-1:0] m_axis_tdata_o    // [6:0] hours, [13:7] minutes,
                                                     // [20:14] seconds, [23:21] zero
);

  logic         accept, push, not_full, not_empty, pop;
  time_digits_t push_data, pop_data;

  assign s_axis_tready_o = not_full;
  assign accept          = s_axis_tvalid_i && not_full;

  nrte_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .rx_byte_i  (s_axis_tdata_i),
    .push_o     (push),
    .push_data_o(push_data)
  );

  nrte_queue #(
    .Depth(QueueDepthP)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .not_full_o (not_full),
    .not_empty_o(not_empty),
    .pop_i      (pop),
    .pop_data_o (pop_data)
  );

  nrte_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .avail_i   (not_empty),
    .digits_i  (pop_data),
    .pop_o     (pop),
    .m_tvalid_o(m_axis_tvalid_o),
    .m_tready_i(m_axis_tready_i),
    .m_tdata_o (m_axis_tdata_o)
  );

endmodule
`default_nettype wire
